@@ sv/ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for pressure/temperature compensation
// Field widths, register indexes, pipeline tag layout and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

  localparam int RAW_W   = 20;
  localparam int TEMP_W  = 16;
  localparam int PRESS_W = 27;
  localparam int DIV_W   = 64;

  localparam logic [PRESS_W-1:0] PRESS_MAX   = '1;
  localparam logic [63:0]        TFINE_OFS   = 64'd128000;
  localparam logic [63:0]        DIV_BIAS    = 64'h0000_8000_0000_0000;
  localparam logic [63:0]        PRESS_SCALE = 64'd3125;
  localparam logic [20:0]        P_FULL      = 21'h10_0000;

  typedef enum logic [1:0] {
    REG_TEMP       = 2'd0,
    REG_PRESS_LO   = 2'd1,
    REG_PRESS_HI   = 2'd2,
    REG_PRESS_NINE = 2'd3
  } reg_idx_t;

  // side data that rides along the pipeline with each word
  typedef struct packed {
    logic [RAW_W-1:0]         adcp;
    logic signed [TEMP_W-1:0] temp;
    logic                     fault;
    logic                     neg;
  } tag_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [PRESS_W-1:0]       press;
    logic                     fault;
  } res_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

`default_nettype wire

@@ sv/ptc_if.sv @@
// ----------------------------------------------------------------------------
// ptc_if: valid/ready stream interfaces for raw samples and results
// One interface per channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptc_in_if
  import ptc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface ptc_out_if
  import ptc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic [PRESS_W-1:0]       pressure_frac_pa;
  logic                     divide_fault;

  modport source (output valid, output temperature_centi, output pressure_frac_pa,
                  output divide_fault, input ready);
  modport sink   (input valid, input temperature_centi, input pressure_frac_pa,
                  input divide_fault, output ready);
endinterface

`default_nettype wire

@@ sv/ptc_mul64.sv @@
// ----------------------------------------------------------------------------
// ptc_mul64: two-stage pipelined 64x64 multiplier, low 64 bits of product
// Three 32x32 partial products are registered, then summed.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll_w, lh_w, hl_w;
  logic [63:0] ll_r;
  logic [31:0] lh_r, hl_r;
  logic [63:0] p_r;

  assign ll_w = a[31:0] * b[31:0];
  assign lh_w = a[31:0] * b[63:32];
  assign hl_w = a[63:32] * b[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= ll_w;
      lh_r <= lh_w[31:0];
      hl_r <= hl_w[31:0];
      p_r  <= ll_r + {lh_r + hl_r, 32'b0};
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

@@ sv/ptc_div.sv @@
// ----------------------------------------------------------------------------
// ptc_div: pipelined unsigned restoring divider, one quotient bit per stage
// W register stages; a side tag and a valid bit travel with each word.
// ----------------------------------------------------------------------------
`default_nettype none

module ptc_div #(
  parameter int W     = 64,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [W-1:0]     num,
  input  logic [W-1:0]     den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [W-1:0]     quo,
  output logic [TAG_W-1:0] out_tag
);

  logic [W-1:0]     rem_r [W-1];
  logic [W-1:0]     d_r   [W-1];
  logic [W-1:0]     nq_r  [W];
  logic [TAG_W-1:0] tag_r [W];
  logic [W-1:0]     v_r;

  logic [W:0]       rr_w  [W];
  logic [W:0]       df_w  [W];
  logic [W-1:0]     rem_nxt [W-1];
  logic [W-1:0]     nq_nxt  [W];

  always_comb begin
    rr_w[0]  = {{W{1'b0}}, num[W-1]};
    df_w[0]  = rr_w[0] - {1'b0, den};
    nq_nxt[0] = {num[W-2:0], ~df_w[0][W]};
    for (int k = 1; k < W; k++) begin
      rr_w[k]   = {rem_r[k-1], nq_r[k-1][W-1]};
      df_w[k]   = rr_w[k] - {1'b0, d_r[k-1]};
      nq_nxt[k] = {nq_r[k-1][W-2:0], ~df_w[k][W]};
    end
    for (int k = 0; k < W - 1; k++) begin
      rem_nxt[k] = df_w[k][W] ? rr_w[k][W-1:0] : df_w[k][W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0]   <= den;
      tag_r[0] <= in_tag;
      for (int k = 1; k < W - 1; k++) begin
        d_r[k] <= d_r[k-1];
      end
      for (int k = 1; k < W; k++) begin
        tag_r[k] <= tag_r[k-1];
      end
      for (int k = 0; k < W - 1; k++) begin
        rem_r[k] <= rem_nxt[k];
      end
      for (int k = 0; k < W; k++) begin
        nq_r[k] <= nq_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[W-2:0], in_valid};
    end
  end

  assign out_valid = v_r[W-1];
  assign quo       = nq_r[W-1];
  assign out_tag   = tag_r[W-1];

endmodule

`default_nettype wire

@@ sv/pressure_temperature_compensation.sv @@
// ----------------------------------------------------------------------------
// pressure_temperature_compensation: integer barometric sensor compensation
// Fully pipelined temperature and pressure compensation with APB coefficients.
// ----------------------------------------------------------------------------
// Usage
//   in_s  : one word = raw 20-bit pressure and temperature readings.
//   out_m : one word = temperature in 0.01 C, pressure in Pa*256 and a
//           divide-fault flag (pressure forced to 0 when the divisor is 0).
//   APB   : four coefficient registers at byte address 8*i; write them
//           only while no word is in flight. Reads return the register.
// Pipeline: 17 front stages, 64 divider stages, 7 back stages, output
//   register. Throughput: one word per cycle while the skid register is
//   empty; the 64-stage restoring divider, one quotient bit per stage, sets
//   the depth, and the 64-bit multiplies are split into 32x32 partial
//   products over two stages each.
// Stall: the whole pipe advances together while the skid register is
//   empty, so a word is still accepted while a result waits on out_m;
//   the next finished word parks in the skid and in_s.ready drops.
// Reset (rst_n low, synchronous): all valid bits clear, coefficients 0.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ptc_in_if.sink      in_s,
  ptc_out_if.source   out_m,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // ---------------- configuration registers ----------------
  logic [47:0] temp_r;
  logic [63:0] plo_r, phi_r;
  logic [15:0] p9_r;
  reg_idx_t    cfg_idx;

  assign cfg_idx = reg_idx_t'(paddr[4:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r <= '0;
      plo_r  <= '0;
      phi_r  <= '0;
      p9_r   <= '0;
    end else if (psel && penable && pwrite) begin
      case (cfg_idx)
        REG_TEMP:       temp_r <= pwdata[47:0];
        REG_PRESS_LO:   plo_r  <= pwdata;
        REG_PRESS_HI:   phi_r  <= pwdata;
        REG_PRESS_NINE: p9_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TEMP:       prdata = {16'b0, temp_r};
      REG_PRESS_LO:   prdata = plo_r;
      REG_PRESS_HI:   prdata = phi_r;
      REG_PRESS_NINE: prdata = {48'b0, p9_r};
      default:        prdata = '0;
    endcase
  end

  // coefficient fields
  logic [15:0]        t1;
  logic signed [15:0] t2s, t3s;
  assign t1  = temp_r[15:0];
  assign t2s = temp_r[31:16];
  assign t3s = temp_r[47:32];

  // ---------------- pipeline control ----------------
  logic en;
  logic skid_v_r, out_v_r;
  res_t skid_d_r, out_d_r, last_d;
  logic [17:1] fv_r;
  logic [7:1]  bv_r;

  // advance everything while the skid is free
  assign en         = !skid_v_r;
  assign in_s.ready = en;

  // ---------------- temperature path, stages 1..6 ----------------
  tag_t               ft_r [1:17];
  logic [RAW_W-1:0]   adct1_r;
  logic signed [17:0] d1_2_r;
  logic signed [16:0] d2_2_r;
  logic signed [31:0] m1_3_r, m2_3_r;
  logic signed [31:0] v1_4_r, m3_4_r;
  logic signed [31:0] tfine_5_r;
  logic [63:0]        a_6_r;

  logic signed [17:0] d1_nxt;
  logic signed [16:0] d2_nxt;
  logic signed [33:0] prod1, prod2;
  logic signed [35:0] prod3;
  logic signed [31:0] tc32;
  logic signed [23:0] tc24;
  logic signed [15:0] temp_sat;

  assign d1_nxt = $signed({1'b0, adct1_r[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d2_nxt = $signed({1'b0, adct1_r[19:4]}) - $signed({1'b0, t1});
  assign prod1  = d1_2_r * t2s;
  assign prod2  = d2_2_r * d2_2_r;
  assign prod3  = $signed(m2_3_r[31:12]) * t3s;
  assign tc32   = (tfine_5_r <<< 2) + tfine_5_r + 32'sd128;
  assign tc24   = tc32[31:8];

  // clamp to the 16-bit field
  always_comb begin
    if (tc24 < -24'sd32768) begin
      temp_sat = 16'sh8000;
    end else if (tc24 > 24'sd32767) begin
      temp_sat = 16'sh7FFF;
    end else begin
      temp_sat = tc24[15:0];
    end
  end

  // ---------------- pressure path, front ----------------
  logic [63:0] m_aa, m_ap5, m_ap2, m_aap6, m_aap3, m_y, m_num;
  logic [63:0] ap5s_9_r, ap2s_9_r, ap5s_10_r, ap2s_10_r;
  logic [63:0] b_11_r, x_11_r, b_12_r, b_13_r;
  logic [63:0] den_14_r, num_14_r, den_15_r, den_16_r;
  logic [63:0] mn_17_r, md_17_r;
  logic [20:0] pdiff;

  assign pdiff = P_FULL - {1'b0, ft_r[13].adcp};

  ptc_mul64 u_m_aa   (.clk, .en, .a(a_6_r), .b(a_6_r),               .p(m_aa));
  ptc_mul64 u_m_ap5  (.clk, .en, .a(a_6_r), .b(sx16(phi_r[15:0])),   .p(m_ap5));
  ptc_mul64 u_m_ap2  (.clk, .en, .a(a_6_r), .b(sx16(plo_r[31:16])),  .p(m_ap2));
  ptc_mul64 u_m_aap6 (.clk, .en, .a(m_aa),  .b(sx16(phi_r[31:16])),  .p(m_aap6));
  ptc_mul64 u_m_aap3 (.clk, .en, .a(m_aa),  .b(sx16(plo_r[47:32])),  .p(m_aap3));
  ptc_mul64 u_m_y    (.clk, .en, .a(x_11_r), .b({48'b0, plo_r[15:0]}), .p(m_y));
  ptc_mul64 u_m_num  (.clk, .en, .a(num_14_r), .b(PRESS_SCALE),       .p(m_num));

  always_ff @(posedge clk) begin
    if (en) begin
      adct1_r  <= in_s.raw_temperature;
      ft_r[1]  <= '{adcp: in_s.raw_pressure, temp: '0, fault: 1'b0, neg: 1'b0};
      for (int i = 2; i <= 5; i++) begin
        ft_r[i] <= ft_r[i-1];
      end
      // load the clamped temperature into the tag
      ft_r[6]  <= '{adcp: ft_r[5].adcp, temp: temp_sat, fault: ft_r[5].fault,
                    neg: ft_r[5].neg};
      for (int i = 7; i <= 16; i++) begin
        ft_r[i] <= ft_r[i-1];
      end
      // sign-magnitude split ahead of the unsigned divider
      ft_r[17] <= '{adcp: ft_r[16].adcp, temp: ft_r[16].temp,
                    fault: (den_16_r == 64'd0), neg: m_num[63] ^ den_16_r[63]};
      d1_2_r    <= d1_nxt;
      d2_2_r    <= d2_nxt;
      m1_3_r    <= prod1[31:0];
      m2_3_r    <= prod2[31:0];
      v1_4_r    <= m1_3_r >>> 11;
      m3_4_r    <= prod3[31:0];
      tfine_5_r <= v1_4_r + (m3_4_r >>> 14);
      a_6_r     <= {{32{tfine_5_r[31]}}, tfine_5_r} - TFINE_OFS;
      ap5s_9_r  <= m_ap5 << 17;
      ap2s_9_r  <= m_ap2 << 12;
      ap5s_10_r <= ap5s_9_r;
      ap2s_10_r <= ap2s_9_r;
      b_11_r    <= m_aap6 + ap5s_10_r + (sx16(plo_r[63:48]) << 35);
      x_11_r    <= 64'($signed(m_aap3) >>> 8) + ap2s_10_r + DIV_BIAS;
      b_12_r    <= b_11_r;
      b_13_r    <= b_12_r;
      den_14_r  <= 64'($signed(m_y) >>> 33);
      num_14_r  <= ({43'b0, pdiff} << 31) - b_13_r;
      den_15_r  <= den_14_r;
      den_16_r  <= den_15_r;
      mn_17_r   <= m_num[63] ? (64'd0 - m_num) : m_num;
      md_17_r   <= den_16_r[63] ? (64'd0 - den_16_r) : den_16_r;
    end
  end

  // ---------------- divider ----------------
  logic                     dv;
  logic [DIV_W-1:0]         dq;
  logic [$bits(tag_t)-1:0]  dtag_w;
  tag_t                     dtag;

  ptc_div #(.W(DIV_W), .TAG_W($bits(tag_t))) u_div (
    .clk, .rst_n, .en,
    .in_valid (fv_r[17]),
    .num      (mn_17_r),
    .den      (md_17_r),
    .in_tag   (ft_r[17]),
    .out_valid(dv),
    .quo      (dq),
    .out_tag  (dtag_w)
  );

  assign dtag = tag_t'(dtag_w);

  // ---------------- pressure path, back ----------------
  tag_t        bt_r [1:7];
  logic [63:0] p_b1_r, p_b2_r, p_b3_r, p_b4_r, p_b5_r;
  logic [63:0] c2_b4_r, c2_b5_r, s_b6_r;
  logic [PRESS_W-1:0] press_b7_r;
  logic [63:0] m_phph, m_p8p, m_c1, ph_w, r_w;

  assign ph_w = 64'($signed(p_b1_r) >>> 13);
  assign r_w  = 64'($signed(s_b6_r) >>> 8) + (sx16(phi_r[47:32]) << 4);

  ptc_mul64 u_m_phph (.clk, .en, .a(ph_w),   .b(ph_w),               .p(m_phph));
  ptc_mul64 u_m_p8p  (.clk, .en, .a(p_b1_r), .b(sx16(phi_r[63:48])), .p(m_p8p));
  ptc_mul64 u_m_c1   (.clk, .en, .a(m_phph), .b(sx16(p9_r)),         .p(m_c1));

  always_ff @(posedge clk) begin
    if (en) begin
      bt_r[1] <= dtag;
      for (int i = 2; i <= 7; i++) begin
        bt_r[i] <= bt_r[i-1];
      end
      p_b1_r  <= dtag.neg ? (64'd0 - dq) : dq;
      p_b2_r  <= p_b1_r;
      p_b3_r  <= p_b2_r;
      p_b4_r  <= p_b3_r;
      p_b5_r  <= p_b4_r;
      c2_b4_r <= 64'($signed(m_p8p) >>> 19);
      c2_b5_r <= c2_b4_r;
      s_b6_r  <= p_b5_r + 64'($signed(m_c1) >>> 25) + c2_b5_r;
      // saturate; zero divisor forces 0
      if (bt_r[6].fault || r_w[63]) begin
        press_b7_r <= '0;
      end else if (r_w > {37'b0, PRESS_MAX}) begin
        press_b7_r <= PRESS_MAX;
      end else begin
        press_b7_r <= r_w[PRESS_W-1:0];
      end
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
      bv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[16:1], in_s.valid};
      bv_r <= {bv_r[6:1], dv};
    end
  end

  // ---------------- output register and skid ----------------
  assign last_d = '{temp: bt_r[7].temp, press: press_b7_r, fault: bt_r[7].fault};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_m.ready) begin
      // drain the skid first, else take the pipe head
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        out_d_r  <= skid_d_r;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= bv_r[7];
        out_d_r <= last_d;
      end
    end else if (bv_r[7] && en) begin
      // hold the output; park the arriving word
      skid_v_r <= 1'b1;
      skid_d_r <= last_d;
    end
  end

  assign out_m.valid             = out_v_r;
  assign out_m.temperature_centi = out_d_r.temp;
  assign out_m.pressure_frac_pa  = out_d_r.press;
  assign out_m.divide_fault      = out_d_r.fault;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a word while the output register is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_m.ready) |=> (out_v_r && $stable(out_d_r)))
    else $error("stalled result changed");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_d_r.fault) |-> (out_d_r.press == '0))
    else $error("divide fault with nonzero pressure");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_m.ready) |=> (out_v_r && !skid_v_r))
    else $error("skid failed to drain");

endmodule

`default_nettype wire

@@ sim/pressure_temperature_compensation_test.sv @@
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_test: self-checking bench for the
// barometric compensation pipeline
// Drives raw reading pairs through the input stream under random idling and
// a long output hold-off. Each result word is checked field by field against
// an in-bench integer predictor. Coefficient sets are changed over APB
// between phases, with the pipe drained first.
// ----------------------------------------------------------------------------
`default_nettype none

module pressure_temperature_compensation_test;
  import ptc_pkg::*;

  localparam int LATENCY   = 88;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1550;
  localparam int N_PHASES  = 6;

  typedef struct packed {
    logic [RAW_W-1:0] adcp;
    logic [RAW_W-1:0] adct;
    logic             chk;       // typed-in expectation present
    logic [15:0]      temp;
    logic [26:0]      press;
    logic             fault;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  ptc_in_if  in_w ();
  ptc_out_if out_w ();

  pressure_temperature_compensation u_dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_w.sink), .out_m(out_w.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // coefficient shadow copies
  logic [47:0] coef_temp;
  logic [63:0] coef_plo, coef_phi;
  logic [15:0] coef_p9;

  res_t comp_expected [$];
  int   mismatch_cnt = 0;
  int   idle_pct = 24;       // sender and receiver idle odds, in percent
  bit   hold_sink = 1'b0;    // long receiver hold-off
  int   wdog = 0;
  bit   fin = 1'b0;

  // Compensate one reading pair with the current coefficients.
  function automatic res_t compensate(input logic [19:0] adcp, input logic [19:0] adct);
    logic [31:0] t1, t2, t3, d1, d2, v1, v2, tfine, tc;
    logic signed [63:0] p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, ph, c1, c2, num, ip;
    logic [63:0] na, da, q;
    res_t r;
    t1 = {16'd0, coef_temp[15:0]};
    t2 = {{16{coef_temp[31]}}, coef_temp[31:16]};
    t3 = {{16{coef_temp[47]}}, coef_temp[47:32]};
    d1 = {15'd0, adct[19:3]} - (t1 << 1);
    v1 = $unsigned($signed(d1 * t2) >>> 11);
    d2 = {16'd0, adct[19:4]} - t1;
    v2 = $unsigned($signed(d2 * d2) >>> 12);
    v2 = $unsigned($signed(v2 * t3) >>> 14);
    tfine = v1 + v2;
    tc = $unsigned($signed(tfine * 32'd5 + 32'd128) >>> 8);
    if ($signed(tc) < -32768) r.temp = -16'sd32768;
    else if ($signed(tc) > 32767) r.temp = 16'sd32767;
    else r.temp = tc[15:0];

    p2 = $signed({{48{coef_plo[31]}}, coef_plo[31:16]});
    p3 = $signed({{48{coef_plo[47]}}, coef_plo[47:32]});
    p4 = $signed({{48{coef_plo[63]}}, coef_plo[63:48]});
    p5 = $signed({{48{coef_phi[15]}}, coef_phi[15:0]});
    p6 = $signed({{48{coef_phi[31]}}, coef_phi[31:16]});
    p7 = $signed({{48{coef_phi[47]}}, coef_phi[47:32]});
    p8 = $signed({{48{coef_phi[63]}}, coef_phi[63:48]});
    p9 = $signed({{48{coef_p9[15]}}, coef_p9});
    a = $signed({{32{tfine[31]}}, tfine}) - 64'sd128000;
    b = a * a * p6 + ((a * p5) <<< 17) + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = ((64'sh0000_8000_0000_0000 + a) * $signed({48'd0, coef_plo[15:0]})) >>> 33;
    r.fault = 1'b0;
    r.press = '0;
    if (a == 0) begin
      r.fault = 1'b1;
    end else begin
      ip = 64'sd1048576 - $signed({44'd0, adcp});
      num = ((ip <<< 31) - b) * 64'sd3125;
      // truncating division on magnitudes; most negative / -1 wraps
      na = num[63] ? -num : num;
      da = a[63] ? -a : a;
      q = na / da;
      p = (num[63] != a[63]) ? -$signed(q) : $signed(q);
      ph = p >>> 13;
      c1 = (p9 * ph * ph) >>> 25;
      c2 = (p8 * p) >>> 19;
      p = ((p + c1 + c2) >>> 8) + (p7 <<< 4);
      if (p < 0) r.press = '0;
      else if (p > 64'sd134217727) r.press = PRESS_MAX;
      else r.press = p[26:0];
    end
    return r;
  endfunction

  // APB write: setup then access
  task automatic coef_write(input reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 3; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_TEMP:       coef_temp = val[47:0];
      REG_PRESS_LO:   coef_plo  = val;
      REG_PRESS_HI:   coef_phi  = val;
      REG_PRESS_NINE: coef_p9   = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_coefs(input logic [47:0] t, input logic [63:0] lo,
                            input logic [63:0] hi, input logic [15:0] n9);
    coef_write(REG_TEMP, {16'd0, t});
    coef_write(REG_PRESS_LO, lo);
    coef_write(REG_PRESS_HI, hi);
    coef_write(REG_PRESS_NINE, {48'd0, n9});
  endtask

  // Offer one word, hold it until accepted, then log its expectation.
  task automatic send_word(input logic [19:0] adcp, input logic [19:0] adct);
    while ($urandom_range(99) < idle_pct) begin
      in_w.valid <= 1'b0;
      @(posedge clk);
    end
    in_w.valid <= 1'b1;
    in_w.raw_pressure <= adcp;
    in_w.raw_temperature <= adct;
    @(posedge clk);
    while (!in_w.ready) @(posedge clk);
    comp_expected.push_back(compensate(adcp, adct));
  endtask

  task automatic drain_pipe();
    in_w.valid <= 1'b0;
    while (comp_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_w.ready <= 1'b0;
    end else begin
      out_w.ready <= !hold_sink && ($urandom_range(99) >= idle_pct);
    end
  end

  // check every accepted result against the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_w.valid && out_w.ready) begin
      if (comp_expected.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result word temp=%0d press=%0d fault=%0b",
                   out_w.temperature_centi, out_w.pressure_frac_pa, out_w.divide_fault);
      end else begin
        want = comp_expected.pop_front();
        if (out_w.temperature_centi !== want.temp || out_w.pressure_frac_pa !== want.press ||
            out_w.divide_fault !== want.fault) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp temp=%0d press=%0d fault=%0b got temp=%0d press=%0d fault=%0b",
                     want.temp, want.press, want.fault, out_w.temperature_centi,
                     out_w.pressure_frac_pa, out_w.divide_fault);
        end
      end
    end
  end

  // watchdog: count cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready) || !rst_n || fin)
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // directed table: extremes with reset coefficients have typed-in results
  stim_row_t dir_rows [$];

  initial begin
    logic [19:0] rp, rt;
    res_t got;
    int n;
    in_w.valid = 1'b0;
    in_w.raw_pressure = '0;
    in_w.raw_temperature = '0;
    coef_temp = '0; coef_plo = '0; coef_phi = '0; coef_p9 = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // after reset all coefficients are 0: temperature 0, P1 = 0 gives divide fault
    dir_rows.push_back('{20'h00000, 20'h00000, 1'b1, 16'd0, 27'd0, 1'b1});
    dir_rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b1, 16'd0, 27'd0, 1'b1});
    dir_rows.push_back('{20'hAAAAA, 20'h55555, 1'b1, 16'd0, 27'd0, 1'b1});
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].adcp, dir_rows[i].adct);
      got = comp_expected[$];
      if (got.temp !== dir_rows[i].temp || got.press !== dir_rows[i].press ||
          got.fault !== dir_rows[i].fault) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("row %0d: exp temp=%0d press=%0d fault=%0b got temp=%0d press=%0d fault=%0b",
                   i, dir_rows[i].temp, dir_rows[i].press, dir_rows[i].fault,
                   got.temp, got.press, got.fault);
      end
    end
    drain_pipe();

    // typical calibration set, then extreme readings through the predictor
    load_coefs({16'hFC18, 16'h6672, 16'd27504},
               {16'd2855, 16'hE58A, 16'h0BD0, 16'd36477},
               {16'hFFF9, 16'd15500, 16'hFF7D, 16'd140}, 16'd6000);
    dir_rows.delete();
    dir_rows.push_back('{20'd415148, 20'd519888, 1'b0, '0, '0, 1'b0});
    dir_rows.push_back('{20'h00000, 20'h00000, 1'b0, '0, '0, 1'b0});
    dir_rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b0, '0, '0, 1'b0});
    dir_rows.push_back('{20'h00000, 20'hFFFFF, 1'b0, '0, '0, 1'b0});
    dir_rows.push_back('{20'hFFFFF, 20'h00000, 1'b0, '0, '0, 1'b0});
    dir_rows.push_back('{20'h80000, 20'h80000, 1'b0, '0, '0, 1'b0});
    foreach (dir_rows[i]) send_word(dir_rows[i].adcp, dir_rows[i].adct);
    drain_pipe();

    // extreme coefficients: saturation and wraparound
    load_coefs('1, '1, '1, 16'h7FFF);
    send_word(20'hFFFFF, 20'hFFFFF);
    send_word(20'h00000, 20'h00000);
    send_word(20'h12345, 20'hEDCBA);
    drain_pipe();
    load_coefs({16'h8000, 16'h7FFF, 16'hFFFF},
               {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
               {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
    send_word(20'hFFFFF, 20'h00000);
    send_word(20'h00000, 20'hFFFFF);
    send_word(20'h7FFFF, 20'h7FFFF);
    drain_pipe();

    // random phases with fresh coefficient sets
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph % 2 == 0)
        load_coefs({16'($urandom_range(1000) - 500), 16'($urandom_range(27000, 26000)),
                    16'($urandom_range(29000, 26000))},
                   {16'($urandom_range(4000, 1000)), 16'($urandom_range(65535, 62000)),
                    16'($urandom_range(16000, 1000)), 16'($urandom_range(40000, 30000))},
                   {16'($urandom_range(100)), 16'($urandom_range(65535, 64000)),
                    16'($urandom_range(16000, 14000)), 16'($urandom_range(200))},
                   16'($urandom));
      else
        load_coefs(48'({$urandom, $urandom}), {$urandom, $urandom},
                   {$urandom, $urandom}, 16'($urandom));
      idle_pct = (ph == 1) ? 0 : 24;
      n = N_RANDOM / N_PHASES;
      for (int k = 0; k < n; k++) begin
        if (ph == 2 && k == 20) begin
          // hold off the receiver so the pipe fills and the input stalls
          fork
            begin
              hold_sink = 1'b1;
              repeat (400) @(posedge clk);
              hold_sink = 1'b0;
            end
          join_none
        end
        if (ph % 2 == 0) begin
          rp = 20'($urandom_range(600000, 200000));
          rt = 20'($urandom_range(560000, 460000));
        end else begin
          rp = 20'($urandom);
          rt = 20'($urandom);
        end
        send_word(rp, rt);
      end
      drain_pipe();
    end

    fin = 1'b1;
    if (mismatch_cnt == 0 && comp_expected.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
